FILE: sv/lprf_pkg.sv
// ----------------------------------------------------------------------------
// lprf_pkg
// Shared widths and sequencer states of the least primitive root finder.
// ----------------------------------------------------------------------------
package lprf_pkg;

    localparam int MODULUS_BITS = 16;
    localparam int PROD_BITS    = 2 * MODULUS_BITS;
    localparam int MAX_PRIMES   = 8;
    localparam int PIDX_BITS    = $clog2(MAX_PRIMES);
    localparam int PCNT_BITS    = PIDX_BITS + 1;
    localparam int DCNT_BITS    = $clog2(PROD_BITS);

    typedef logic [MODULUS_BITS-1:0] word_t;
    typedef logic [PROD_BITS-1:0]    prod_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_F_CHECK,
        ST_F_WAIT,
        ST_F_END,
        ST_EXIST,
        ST_TOT_START,
        ST_TOT_WAIT,
        ST_G_TEST,
        ST_GCD_START,
        ST_GCD_WAIT,
        ST_Q_START,
        ST_Q_WAIT,
        ST_PW_LOOP,
        ST_PW_R,
        ST_PW_B,
        ST_DONE
    } state_t;

endpackage

FILE: sv/lprf_divider.sv
// ----------------------------------------------------------------------------
// lprf_divider
// Restoring divider, one quotient bit per cycle, shared by every modulo
// and division step of the sequencer.
// ----------------------------------------------------------------------------
module lprf_divider (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  lprf_pkg::prod_t      num,
    input  lprf_pkg::word_t      den,
    output logic                 done,
    output lprf_pkg::prod_t      quo,
    output lprf_pkg::word_t      rem
);
    import lprf_pkg::*;

    logic                     busy_reg;
    logic                     done_reg;
    logic [DCNT_BITS-1:0]     cnt_reg;
    prod_t                    q_reg;
    word_t                    r_reg;
    word_t                    den_reg;
    logic [MODULUS_BITS:0]    trial;
    logic [MODULUS_BITS:0]    diff;
    logic                     ge;

    assign trial = {r_reg, q_reg[PROD_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_BITS'(PROD_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            r_reg   <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            q_reg <= {q_reg[PROD_BITS-2:0], ge};
            r_reg <= ge ? diff[MODULUS_BITS-1:0] : trial[MODULUS_BITS-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;
    assign rem  = r_reg;

endmodule

FILE: sv/least_primitive_root_finder_core.sv
// ----------------------------------------------------------------------------
// least_primitive_root_finder_core
// Finds the least primitive root of a 16-bit modulus with a small sequencer
// around one shared multiplier and one shared bit-serial divider.
// ----------------------------------------------------------------------------
// Sequencing: a modulus below 3 goes straight from idle to the done state, which
// registers the result beat once the output register is free; otherwise run time is
// data dependent, each division or modulo taking a full pass of the shared divider.
// Throughput: one beat at a time; s_tready is high only while idle.
// Reset: synchronous active-low aresetn returns to idle with no result held.
module least_primitive_root_finder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] modulus
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] root
    output logic [0:0]  m_tuser    // [0] root_exists
);
    import lprf_pkg::*;

    state_t                 state_reg, state_next;
    word_t                  n_reg, n_next;
    word_t                  m_reg, m_next;
    word_t                  d_reg, d_next;
    word_t                  last_reg, last_next;
    logic [PCNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [PCNT_BITS-1:0]   ncnt_reg, ncnt_next;
    logic [PCNT_BITS-1:0]   idx_reg, idx_next;
    logic                   fmode_reg, fmode_next;
    word_t                  tot_reg, tot_next;
    word_t                  g_reg, g_next;
    word_t                  a_reg, a_next;
    word_t                  b_reg, b_next;
    word_t                  e_reg, e_next;
    word_t                  r_reg, r_next;
    word_t                  root_reg, root_next;
    logic                   exists_reg, exists_next;
    logic                   out_valid_reg, out_valid_next;
    word_t                  out_root_reg, out_root_next;
    logic                   out_exists_reg, out_exists_next;
    word_t                  prm_reg [MAX_PRIMES];

    logic                   prm_we;
    word_t                  prm_wd;
    word_t                  prm_cur;
    word_t                  mul_a, mul_b;
    prod_t                  prod;
    logic                   div_start;
    prod_t                  div_num;
    word_t                  div_den;
    logic                   div_done;
    prod_t                  div_quo;
    word_t                  div_rem;

    lprf_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    assign prm_cur = prm_reg[idx_reg[PIDX_BITS-1:0]];
    assign prod    = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg          <= n_next;
        m_reg          <= m_next;
        d_reg          <= d_next;
        last_reg       <= last_next;
        cnt_reg        <= cnt_next;
        ncnt_reg       <= ncnt_next;
        idx_reg        <= idx_next;
        fmode_reg      <= fmode_next;
        tot_reg        <= tot_next;
        g_reg          <= g_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        e_reg          <= e_next;
        r_reg          <= r_next;
        root_reg       <= root_next;
        exists_reg     <= exists_next;
        out_root_reg   <= out_root_next;
        out_exists_reg <= out_exists_next;
        if (prm_we && cnt_reg < PCNT_BITS'(MAX_PRIMES)) begin
            prm_reg[cnt_reg[PIDX_BITS-1:0]] <= prm_wd;
        end
    end

    always_comb begin
        state_next      = state_reg;
        n_next          = n_reg;
        m_next          = m_reg;
        d_next          = d_reg;
        last_next       = last_reg;
        cnt_next        = cnt_reg;
        ncnt_next       = ncnt_reg;
        idx_next        = idx_reg;
        fmode_next      = fmode_reg;
        tot_next        = tot_reg;
        g_next          = g_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        e_next          = e_reg;
        r_next          = r_reg;
        root_next       = root_reg;
        exists_next     = exists_reg;
        out_valid_next  = out_valid_reg;
        out_root_next   = out_root_reg;
        out_exists_next = out_exists_reg;
        prm_we          = 1'b0;
        prm_wd          = d_reg;
        mul_a           = d_reg;
        mul_b           = d_reg;
        div_start       = 1'b0;
        div_num         = PROD_BITS'(m_reg);
        div_den         = d_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_next      = s_tdata[MODULUS_BITS-1:0];
                    m_next      = s_tdata[MODULUS_BITS-1:0];
                    d_next      = MODULUS_BITS'(2);
                    last_next   = '0;
                    cnt_next    = '0;
                    fmode_next  = 1'b0;
                    root_next   = '0;
                    exists_next = (s_tdata[MODULUS_BITS-1:0] != '0);
                    if (s_tdata[MODULUS_BITS-1:0] < MODULUS_BITS'(3)) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_F_CHECK;
                    end
                end
            end
            // Trial division: test d while d squared does not exceed m.
            ST_F_CHECK: begin
                if (prod <= PROD_BITS'(m_reg)) begin
                    div_start  = 1'b1;
                    state_next = ST_F_WAIT;
                end else begin
                    state_next = ST_F_END;
                end
            end
            ST_F_WAIT: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        if (d_reg != last_reg) begin
                            prm_we   = 1'b1;
                            cnt_next = (cnt_reg < PCNT_BITS'(MAX_PRIMES)) ?
                                       cnt_reg + 1'b1 : cnt_reg;
                        end
                        last_next = d_reg;
                        m_next    = div_quo[MODULUS_BITS-1:0];
                    end else begin
                        d_next = d_reg + 1'b1;
                    end
                    state_next = ST_F_CHECK;
                end
            end
            // What is left above one is a prime factor, unless it is the
            // factor just divided out.
            ST_F_END: begin
                prm_wd = m_reg;
                if (m_reg > MODULUS_BITS'(1) && m_reg != last_reg) begin
                    prm_we   = 1'b1;
                    cnt_next = (cnt_reg < PCNT_BITS'(MAX_PRIMES)) ?
                               cnt_reg + 1'b1 : cnt_reg;
                end
                if (fmode_reg) begin
                    g_next     = MODULUS_BITS'(2);
                    state_next = ST_G_TEST;
                end else begin
                    state_next = ST_EXIST;
                end
            end
            ST_EXIST: begin
                if (cnt_reg > PCNT_BITS'(2) || n_reg[2:0] == 3'b000 ||
                    (cnt_reg == PCNT_BITS'(2) &&
                     (prm_reg[0] != MODULUS_BITS'(2) || n_reg[1:0] == 2'b00))) begin
                    exists_next = 1'b0;
                    state_next  = ST_DONE;
                end else begin
                    ncnt_next  = cnt_reg;
                    tot_next   = n_reg;
                    idx_next   = '0;
                    state_next = ST_TOT_START;
                end
            end
            ST_TOT_START: begin
                div_num = PROD_BITS'(tot_reg);
                div_den = prm_cur;
                if (idx_reg == ncnt_reg) begin
                    fmode_next = 1'b1;
                    m_next     = tot_reg;
                    d_next     = MODULUS_BITS'(2);
                    last_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_F_CHECK;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_TOT_WAIT;
                end
            end
            ST_TOT_WAIT: begin
                mul_a = div_quo[MODULUS_BITS-1:0];
                mul_b = prm_cur - 1'b1;
                if (div_done) begin
                    tot_next   = prod[MODULUS_BITS-1:0];
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_TOT_START;
                end
            end
            ST_G_TEST: begin
                if (g_reg >= n_reg) begin
                    state_next = ST_DONE;
                end else begin
                    a_next     = n_reg;
                    b_next     = g_reg;
                    state_next = ST_GCD_START;
                end
            end
            ST_GCD_START: begin
                div_num = PROD_BITS'(a_reg);
                div_den = b_reg;
                if (b_reg == '0) begin
                    if (a_reg == MODULUS_BITS'(1)) begin
                        idx_next   = '0;
                        state_next = ST_Q_START;
                    end else begin
                        g_next     = g_reg + 1'b1;
                        state_next = ST_G_TEST;
                    end
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_GCD_WAIT;
                end
            end
            ST_GCD_WAIT: begin
                if (div_done) begin
                    a_next     = b_reg;
                    b_next     = div_rem;
                    state_next = ST_GCD_START;
                end
            end
            ST_Q_START: begin
                div_num = PROD_BITS'(tot_reg);
                div_den = prm_cur;
                if (idx_reg == cnt_reg) begin
                    root_next  = g_reg;
                    state_next = ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_Q_WAIT;
                end
            end
            ST_Q_WAIT: begin
                if (div_done) begin
                    e_next     = div_quo[MODULUS_BITS-1:0];
                    r_next     = MODULUS_BITS'(1);
                    b_next     = g_reg;
                    state_next = ST_PW_LOOP;
                end
            end
            // Square and multiply, exponent bits taken from the bottom.
            ST_PW_LOOP: begin
                div_den = n_reg;
                mul_a   = b_reg;
                mul_b   = e_reg[0] ? r_reg : b_reg;
                div_num = prod;
                if (e_reg == '0) begin
                    if (r_reg == MODULUS_BITS'(1)) begin
                        g_next     = g_reg + 1'b1;
                        state_next = ST_G_TEST;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_Q_START;
                    end
                end else begin
                    div_start  = 1'b1;
                    state_next = e_reg[0] ? ST_PW_R : ST_PW_B;
                end
            end
            ST_PW_R: begin
                div_den = n_reg;
                mul_a   = b_reg;
                mul_b   = b_reg;
                div_num = prod;
                if (div_done) begin
                    r_next     = div_rem;
                    div_start  = 1'b1;
                    state_next = ST_PW_B;
                end
            end
            ST_PW_B: begin
                if (div_done) begin
                    b_next     = div_rem;
                    e_next     = e_reg >> 1;
                    state_next = ST_PW_LOOP;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next  = 1'b1;
                    out_root_next   = root_reg;
                    out_exists_next = exists_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_root_reg;
    assign m_tuser  = out_exists_reg;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the least primitive root finder: a directed table
// of moduli, then random moduli, each result checked against a fixed expected value or a predictor.
// ----------------------------------------------------------------------------
module tb;

    import lprf_pkg::*;

    localparam int  N_RANDOM    = 80;
    localparam longint CYCLE_CAP = 64'd40_000_000;

    typedef struct packed {
        logic [15:0] root;
        logic        exists;
    } root_res_t;

    typedef struct {
        logic [15:0] modulus;
        logic        known;
        logic [15:0] root;
        logic        exists;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    root_res_t   pending_roots[$];
    int          fail_count;
    longint      cycle_count;
    bit          calm;
    bit          stim_done;

    least_primitive_root_finder_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Distinct prime factors of m, ascending.
    function automatic int distinct_factors(longint unsigned m, ref longint unsigned pf[16]);
        int cnt;
        longint unsigned d;
        cnt = 0;
        d = 2;
        if (m < 2) return 0;
        while (d * d <= m) begin
            if (m % d == 0) begin
                pf[cnt++] = d;
                while (m % d == 0) m = m / d;
            end
            d++;
        end
        if (m > 1) pf[cnt++] = m;
        return cnt;
    endfunction

    function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                                longint unsigned m);
        longint unsigned r;
        r = 1 % m;
        b = b % m;
        while (e != 0) begin
            if (e[0]) r = (r * b) % m;
            b = (b * b) % m;
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic root_res_t least_root(logic [15:0] modulus);
        longint unsigned n, tot, g;
        longint unsigned np[16];
        longint unsigned tp[16];
        int cnt, tc;
        bit ok;
        root_res_t res;
        n = modulus;
        res = '0;
        if (n == 1 || n == 2) begin
            res.exists = 1'b1;
        end else if (n >= 3) begin
            cnt = distinct_factors(n, np);
            res.exists = 1'b1;
            if (cnt > 2 || n % 8 == 0) res.exists = 1'b0;
            if (cnt == 2 && (np[0] != 2 || n % 4 == 0)) res.exists = 1'b0;
            if (res.exists) begin
                tot = n;
                for (int i = 0; i < cnt; i++) tot = tot / np[i] * (np[i] - 1);
                tc = distinct_factors(tot, tp);
                for (g = 2; g < n && res.root == 0; g++) begin
                    ok = (gcd_of(g, n) == 1);
                    for (int i = 0; i < tc && ok; i++)
                        if (pow_mod(g, tot / tp[i], n) == 1) ok = 0;
                    if (ok) res.root = g[15:0];
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        fail_count++;
    endtask

    // The beat stays valid after its handshake; the caller drops it once the
    // last beat of a run has gone.
    task automatic send_modulus(logic [15:0] modulus, root_res_t want);
        while ($urandom_range(99) < 21 && !calm) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= modulus;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_roots.push_back(want);
    endtask

    // Random modulus: mostly small to keep runs short.
    function automatic logic [15:0] pick_modulus();
        int unsigned sel, p;
        sel = $urandom_range(9);
        if (sel < 3) return 16'($urandom);
        p = $urandom_range(2000) | 1;
        case (sel)
            3, 4:    return 16'(p);
            5:       return 16'(2 * p);
            6:       return 16'(p * p);
            7:       return 16'($urandom_range(255));
            default: return 16'($urandom_range(4095));
        endcase
    endfunction

    always @(posedge aclk) begin
        root_res_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_roots.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata, 16'd0);
            end else begin
                want = pending_roots.pop_front();
                if (m_tdata !== want.root) report_mismatch("root", m_tdata, want.root);
                if (m_tuser[0] !== want.exists)
                    report_mismatch("root_exists", 16'(m_tuser), 16'(want.exists));
            end
        end
        m_tready <= (calm || stim_done) ? 1'b1 : ($urandom_range(99) >= 21);
    end

    initial begin
        dir_row_t table_rows[$];
        root_res_t want;
        logic [15:0] modulus;
        table_rows = '{
            '{16'd0,     1'b1, 16'd0, 1'b0},
            '{16'd1,     1'b1, 16'd0, 1'b1},
            '{16'd2,     1'b1, 16'd0, 1'b1},
            '{16'd3,     1'b1, 16'd2, 1'b1},
            '{16'd4,     1'b1, 16'd3, 1'b1},
            '{16'd8,     1'b1, 16'd0, 1'b0},
            '{16'd12,    1'b1, 16'd0, 1'b0},
            '{16'd15,    1'b1, 16'd0, 1'b0},
            '{16'd30,    1'b1, 16'd0, 1'b0},
            '{16'd65535, 1'b1, 16'd0, 1'b0},
            '{16'd32768, 1'b1, 16'd0, 1'b0},
            '{16'd7,     1'b0, 16'd0, 1'b0},
            '{16'd9,     1'b0, 16'd0, 1'b0},
            '{16'd18,    1'b0, 16'd0, 1'b0},
            '{16'd41,    1'b0, 16'd0, 1'b0},
            '{16'd65521, 1'b0, 16'd0, 1'b0},
            '{16'd65522, 1'b0, 16'd0, 1'b0},
            '{16'd59049, 1'b0, 16'd0, 1'b0},
            '{16'd43691, 1'b0, 16'd0, 1'b0},
            '{16'd21845, 1'b0, 16'd0, 1'b0}
        };
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        fail_count  = 0;
        cycle_count = 0;
        calm        = 1'b0;
        stim_done   = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (table_rows[i]) begin
            if (table_rows[i].known)
                want = '{root: table_rows[i].root, exists: table_rows[i].exists};
            else
                want = least_root(table_rows[i].modulus);
            send_modulus(table_rows[i].modulus, want);
        end
        s_tvalid <= 1'b0;

        // Hold off until the block has drained before the random part.
        while (pending_roots.size() != 0) @(posedge aclk);

        for (int i = 0; i < N_RANDOM; i++) begin
            calm = (i >= 40 && i < 60);
            modulus = pick_modulus();
            send_modulus(modulus, least_root(modulus));
        end
        s_tvalid  <= 1'b0;
        calm      = 1'b0;
        stim_done = 1'b1;

        while (pending_roots.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
